>>> hw/rtl/sstf_pkg.sv
// Shared types and constants of the shortest-seek-first request scheduler.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package sstf_pkg;

  localparam int SECTOR_W = 48;
  localparam int COUNT_W  = 16;
  localparam int AGE_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    RES_ADDED      = 2'd0,
    RES_FULL       = 2'd1,
    RES_DISPATCHED = 2'd2,
    RES_NONE       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SCAN,
    S_DRAIN1,
    S_DRAIN2,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic find_step;
    logic scan_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic free_hit;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hw/rtl/sstf_req_if.sv
// Request channel: valid/ready handshake with the add or dispatch payload.
// Depends on sstf_pkg for field widths.
`timescale 1ns / 1ps

interface sstf_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [sstf_pkg::SECTOR_W-1:0] start_sector;
  logic [sstf_pkg::COUNT_W-1:0]  sector_count;
  logic                          is_write;

  modport source (output valid, op, start_sector, sector_count, is_write, input ready);
  modport sink   (input valid, op, start_sector, sector_count, is_write, output ready);
endinterface

>>> hw/rtl/sstf_rsp_if.sv
// Result channel: valid/ready handshake with the status and dispatched request.
// Depends on sstf_pkg for field widths.
`timescale 1ns / 1ps

interface sstf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sstf_pkg::STATUS_W-1:0] status;
  logic [sstf_pkg::SECTOR_W-1:0] out_sector;
  logic [sstf_pkg::COUNT_W-1:0]  out_count;
  logic                          out_write;
  logic                          queue_empty;

  modport source (output valid, status, out_sector, out_count, out_write, queue_empty,
                  input ready);
  modport sink   (input valid, status, out_sector, out_count, out_write, queue_empty,
                  output ready);
endinterface

>>> hw/rtl/sstf_request_scheduler.sv
// Top level of the shortest-seek-first disk request scheduler: controller plus datapath.
// Depends on sstf_pkg, sstf_req_if, sstf_rsp_if, sstf_ctrl and sstf_dp.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid/ready        op, start_sector, sector_count, is_write
//   out_ch    source     valid/ready        status, out_sector, out_count, out_write,
//                                           queue_empty
//
// A dispatch walks the slot memory with one distance comparator through its single read
// port, one slot per cycle, then drains the comparator pipeline before the commit.
// An add searches the valid bits upward from slot 0 for the lowest free slot; a full
// table or an empty dispatch goes straight to the commit.
// Reset (rst_n low at a clock edge) clears all valid bits, the head and the arrival
// counter; no clearing pass is needed. A stalled result holds in the output register;
// the next request is still taken, and its commit waits until the register frees.
`timescale 1ns / 1ps

module sstf_request_scheduler #(
  parameter int QUEUE_DEPTH = 32,
  parameter int SECTOR_BITS = 48
) (
  input logic        clk,
  input logic        rst_n,
  sstf_req_if.sink   in_ch,
  sstf_rsp_if.source out_ch
);

  sstf_pkg::ctrl_cmd_t cmd;
  sstf_pkg::dp_stat_t  stat;

  sstf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  sstf_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_ch.op),
    .in_start_sector (in_ch.start_sector),
    .in_sector_count (in_ch.sector_count),
    .in_is_write     (in_ch.is_write),
    .out_ready       (out_ch.ready),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_sector      (out_ch.out_sector),
    .out_count       (out_ch.out_count),
    .out_write       (out_ch.out_write),
    .out_queue_empty (out_ch.queue_empty)
  );

endmodule

>>> hw/rtl/sstf_ctrl.sv
// Controller state machine of the scheduler: sequences the free-slot search,
// the nearest-request scan and the commit. Depends on sstf_pkg.
`timescale 1ns / 1ps

module sstf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  input  sstf_pkg::dp_stat_t  stat,
  output logic                in_ready,
  output sstf_pkg::ctrl_cmd_t cmd
);

  sstf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sstf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sstf_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == sstf_pkg::OP_DISPATCH) begin
            state_nxt = stat.empty ? sstf_pkg::S_COMMIT : sstf_pkg::S_SCAN;
          end else begin
            state_nxt = stat.full ? sstf_pkg::S_COMMIT : sstf_pkg::S_FIND;
          end
        end
      end
      sstf_pkg::S_FIND: begin
        if (stat.free_hit) state_nxt = sstf_pkg::S_COMMIT;
      end
      sstf_pkg::S_SCAN: begin
        if (stat.scan_last) state_nxt = sstf_pkg::S_DRAIN1;
      end
      sstf_pkg::S_DRAIN1: state_nxt = sstf_pkg::S_DRAIN2;
      sstf_pkg::S_DRAIN2: state_nxt = sstf_pkg::S_COMMIT;
      sstf_pkg::S_COMMIT: begin
        if (stat.out_free) state_nxt = sstf_pkg::S_IDLE;
      end
      default: state_nxt = sstf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == sstf_pkg::S_IDLE);
    cmd.accept    = (state_r == sstf_pkg::S_IDLE) && in_valid;
    cmd.find_step = (state_r == sstf_pkg::S_FIND) && !stat.free_hit;
    cmd.scan_step = (state_r == sstf_pkg::S_SCAN);
    cmd.commit    = (state_r == sstf_pkg::S_COMMIT) && stat.out_free;
  end

endmodule

>>> hw/rtl/sstf_dp.sv
// Datapath of the scheduler: slot memory, valid bits, head and arrival state,
// the pipelined distance comparator and the result register. Depends on sstf_pkg.
`timescale 1ns / 1ps

module sstf_dp #(
  parameter int QUEUE_DEPTH = 32,
  parameter int SECTOR_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sstf_pkg::ctrl_cmd_t           cmd,
  input  logic                          in_op,
  input  logic [sstf_pkg::SECTOR_W-1:0] in_start_sector,
  input  logic [sstf_pkg::COUNT_W-1:0]  in_sector_count,
  input  logic                          in_is_write,
  input  logic                          out_ready,
  output sstf_pkg::dp_stat_t            stat,
  output logic                          out_valid,
  output logic [sstf_pkg::STATUS_W-1:0] out_status,
  output logic [sstf_pkg::SECTOR_W-1:0] out_sector,
  output logic [sstf_pkg::COUNT_W-1:0]  out_count,
  output logic                          out_write,
  output logic                          out_queue_empty
);

  localparam int SW    = sstf_pkg::SECTOR_W;
  localparam int CW    = sstf_pkg::COUNT_W;
  localparam int AW    = sstf_pkg::AGE_W;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = SECTOR_BITS + CW + 1 + AW;

  // Latched request and its outcome class.
  sstf_pkg::status_t       res_r;
  logic [SECTOR_BITS-1:0]  sec_in_r;
  logic [CW-1:0]           cnt_in_r;
  logic                    wr_in_r;

  logic [IDX_W-1:0]        idx_r;
  logic [QUEUE_DEPTH-1:0]  valid_r, valid_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [AW-1:0]           arrival_r, arrival_nxt;
  logic [SECTOR_BITS-1:0]  head_r, head_nxt;
  logic                    mem_we;

  logic [ENT_W-1:0]        mem [QUEUE_DEPTH];
  logic [ENT_W-1:0]        rd_q;

  // Comparator pipeline.
  logic                    p1_vld_r;
  logic [IDX_W-1:0]        p1_idx_r;
  logic [SECTOR_BITS-1:0]  rd_sec;
  logic [CW-1:0]           rd_cnt;
  logic                    rd_wr;
  logic [AW-1:0]           rd_age;

  logic                    p2_vld_r;
  logic [IDX_W-1:0]        p2_idx_r;
  logic [SECTOR_BITS-1:0]  d2_r;
  logic [AW-1:0]           w2_r;
  logic [SECTOR_BITS-1:0]  s2_r;
  logic [CW-1:0]           c2_r;
  logic                    wr2_r;

  logic                    best_found_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic [SECTOR_BITS-1:0]  best_dist_r;
  logic [AW-1:0]           best_wait_r;
  logic [SECTOR_BITS-1:0]  best_sec_r;
  logic [CW-1:0]           best_cnt_r;
  logic                    best_wr_r;
  logic                    take;

  sstf_pkg::status_t       res_nxt;
  logic                    is_disp;

  logic                    out_valid_r;
  sstf_pkg::status_t       status_r;
  logic [SW-1:0]           out_sector_r;
  logic [CW-1:0]           out_count_r;
  logic                    out_write_r;
  logic                    queue_empty_r;

  assign stat.full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty     = (count_r == '0);
  assign stat.free_hit  = !valid_r[idx_r];
  assign stat.scan_last = (idx_r == IDX_W'(QUEUE_DEPTH - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    if (in_op == sstf_pkg::OP_DISPATCH) begin
      res_nxt = stat.empty ? sstf_pkg::RES_NONE : sstf_pkg::RES_DISPATCHED;
    end else begin
      res_nxt = stat.full ? sstf_pkg::RES_FULL : sstf_pkg::RES_ADDED;
    end
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= sstf_pkg::RES_NONE;
    end else if (cmd.accept) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sec_in_r <= SECTOR_BITS'(in_start_sector);
      cnt_in_r <= in_sector_count;
      wr_in_r  <= in_is_write;
    end
  end

  // Slot index: walks the valid bits for an add, the memory for a dispatch.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.accept) begin
      idx_r <= '0;
    end else if (cmd.find_step || (cmd.scan_step && !stat.scan_last)) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  assign is_disp = (res_r == sstf_pkg::RES_DISPATCHED);

  always_comb begin
    valid_nxt   = valid_r;
    count_nxt   = count_r;
    arrival_nxt = arrival_r;
    head_nxt    = head_r;
    mem_we      = 1'b0;
    if (cmd.commit) begin
      case (res_r)
        sstf_pkg::RES_ADDED: begin
          valid_nxt[idx_r] = 1'b1;
          count_nxt        = count_r + CNT_W'(1);
          arrival_nxt      = arrival_r + AW'(1);
          mem_we           = 1'b1;
        end
        sstf_pkg::RES_DISPATCHED: begin
          valid_nxt[best_idx_r] = 1'b0;
          count_nxt             = count_r - CNT_W'(1);
          head_nxt = best_sec_r + SECTOR_BITS'(best_cnt_r) - SECTOR_BITS'(1);
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      count_r   <= '0;
      arrival_r <= '0;
      head_r    <= '0;
    end else begin
      valid_r   <= valid_nxt;
      count_r   <= count_nxt;
      arrival_r <= arrival_nxt;
      head_r    <= head_nxt;
    end
  end

  // Slot memory: one write port for adds, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= {sec_in_r, cnt_in_r, wr_in_r, arrival_r};
    end
    rd_q <= mem[idx_r];
  end

  assign rd_sec = rd_q[ENT_W-1 -: SECTOR_BITS];
  assign rd_cnt = rd_q[AW+1 +: CW];
  assign rd_wr  = rd_q[AW];
  assign rd_age = rd_q[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= cmd.scan_step && valid_r[idx_r];
      p2_vld_r <= p1_vld_r;
    end
  end

  // Distance and waiting time are registered before the compare.
  always_ff @(posedge clk) begin
    p1_idx_r <= idx_r;
    p2_idx_r <= p1_idx_r;
    d2_r     <= (rd_sec >= head_r) ? (rd_sec - head_r) : (head_r - rd_sec);
    w2_r     <= arrival_r - rd_age;
    s2_r     <= rd_sec;
    c2_r     <= rd_cnt;
    wr2_r    <= rd_wr;
  end

  // Nearer wins; on equal distance the lower sector; on equal sector the oldest.
  assign take = !best_found_r || (d2_r < best_dist_r) ||
                ((d2_r == best_dist_r) &&
                 ((s2_r < best_sec_r) || ((s2_r == best_sec_r) && (w2_r > best_wait_r))));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (cmd.accept) begin
      best_found_r <= 1'b0;
    end else if (p2_vld_r) begin
      best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_vld_r && take) begin
      best_idx_r  <= p2_idx_r;
      best_dist_r <= d2_r;
      best_wait_r <= w2_r;
      best_sec_r  <= s2_r;
      best_cnt_r  <= c2_r;
      best_wr_r   <= wr2_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r      <= res_r;
      out_sector_r  <= is_disp ? SW'(best_sec_r) : '0;
      out_count_r   <= is_disp ? best_cnt_r : '0;
      out_write_r   <= is_disp ? best_wr_r : 1'b0;
      queue_empty_r <= (count_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_sector      = out_sector_r;
  assign out_count       = out_count_r;
  assign out_write       = out_write_r;
  assign out_queue_empty = queue_empty_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r)))
    else $error("pending count disagrees with valid bits");

  a_dispatch_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_disp) |-> (best_found_r && valid_r[best_idx_r]))
    else $error("dispatch commit without a pending winner");

  a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (res_r == sstf_pkg::RES_ADDED)) |-> !valid_r[idx_r])
    else $error("add commit into an occupied slot");

  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.commit && is_disp) |=> $stable(head_r))
    else $error("head moved without a dispatch");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.commit)
    else $error("result register overwritten while held");

endmodule
